>>> design/mrpt_pkg.sv
// shared types, codes and kernel region constants for the region protection table
// no dependencies
package mrpt_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int KERNEL_ROWS   = 3;
   localparam int REQ_DATA_W    = 88;
   localparam int RSP_DATA_W    = 16;

   typedef enum logic [1:0] {
      FUNC_ALLOC,
      FUNC_CHECK,
      FUNC_FIND,
      FUNC_FREE
   } func_type;

   typedef enum logic [2:0] {
      STS_OK,
      STS_FULL,
      STS_OVERLAP,
      STS_NOMATCH,
      STS_OWNER,
      STS_PERM,
      STS_BADIDX
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RESP
   } fsm_type;

   typedef struct packed {
      logic [31:0] base;
      logic [31:0] limit;
      logic [2:0]  perm;
      logic [7:0]  owner;
   } entry_type;

   typedef struct packed {
      logic wr_en;
      logic clr_en;
   } tbl_cmd_type;

   function automatic entry_type kernel_entry(input logic [1:0] row);
      entry_type e;
      e.owner = 8'h00;
      case (row)
         2'd0: begin
            e.base  = 32'h0000_0000;
            e.limit = 32'h0001_0000;
            e.perm  = 3'd7;
         end
         2'd1: begin
            e.base  = 32'h0001_0000;
            e.limit = 32'h0002_0000;
            e.perm  = 3'd3;
         end
         default: begin
            e.base  = 32'h0002_0000;
            e.limit = 32'h0003_0000;
            e.perm  = 3'd3;
         end
      endcase
      return e;
   endfunction

endpackage

>>> design/mrpt_table.sv
// region table storage: entry memory with registered read, active bits, kernel rows
// depends on mrpt_pkg
module mrpt_table
   import mrpt_pkg::*;
#(
   parameter int REGION_SLOTS = SLOTS_DEFAULT,
   localparam int IW = $clog2(REGION_SLOTS)
) (
   input  logic        clock,
   input  logic        reset,
   input  tbl_cmd_type cmd,
   input  logic [IW-1:0] wr_idx,
   input  entry_type   wr_entry,
   input  logic [IW-1:0] clr_idx,
   input  logic [IW-1:0] rd_addr,
   output entry_type   rd_entry,
   output logic        rd_active
);

   entry_type mem [REGION_SLOTS];
   entry_type mem_rd_ff;
   logic      kern_ff;
   logic [1:0] krow_ff;
   logic      act_rd_ff;
   logic [REGION_SLOTS-1:0] active_ff;
   logic [REGION_SLOTS-1:0] active_in;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      mem_rd_ff <= mem[rd_addr];
      kern_ff   <= (rd_addr < IW'(KERNEL_ROWS));
      krow_ff   <= rd_addr[1:0];
      act_rd_ff <= active_ff[rd_addr];
   end

   always_comb begin
      active_in = active_ff;
      if (cmd.wr_en) begin
         active_in[wr_idx] = 1'b1;
      end
      if (cmd.clr_en) begin
         active_in[clr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= REGION_SLOTS'({KERNEL_ROWS{1'b1}});
      end else begin
         active_ff <= active_in;
      end
   end

   // kernel rows are never rewritten, so they read from constants
   assign rd_entry  = kern_ff ? kernel_entry(krow_ff) : mem_rd_ff;
   assign rd_active = act_rd_ff;

endmodule

>>> design/mrpt_seq.sv
// request sequencer: walks used slots with one shared range comparator
// depends on mrpt_pkg
module mrpt_seq
   import mrpt_pkg::*;
#(
   parameter int REGION_SLOTS = SLOTS_DEFAULT,
   localparam int IW = $clog2(REGION_SLOTS),
   localparam int CW = $clog2(REGION_SLOTS + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  func_type    req_func,
   input  logic [31:0] req_address,
   input  logic [31:0] req_length,
   input  logic [2:0]  req_perm_bits,
   input  logic [2:0]  req_access_bits,
   input  logic [7:0]  req_owner,
   input  logic [3:0]  req_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output status_type  rsp_status,
   output logic        rsp_allowed,
   output logic        rsp_found,
   output logic [3:0]  rsp_region_index,
   output tbl_cmd_type cmd,
   output logic [IW-1:0] wr_idx,
   output entry_type   wr_entry,
   output logic [IW-1:0] clr_idx,
   output logic [IW-1:0] rd_addr,
   input  entry_type   rd_entry,
   input  logic        rd_active
);

   fsm_type    state_ff, state_in;
   func_type   func_ff, func_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] end_ff, end_in;
   logic [2:0] perm_ff, perm_in;
   logic [2:0] need_ff, need_in;
   logic [7:0] owner_ff, owner_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] used_ff, used_in;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type status_ff, status_in;
   logic       allowed_ff, allowed_in;
   logic       found_ff, found_in;
   logic [3:0] index_ff, index_in;

   logic [CW+3:0] slot_ext;
   logic [CW+3:0] used_ext;
   logic [CW+3:0] idx_ext;
   logic          slot_ok;
   logic          full;
   logic          at_end;
   logic          cmp_lo;
   logic          cmp_hi;
   logic          match;
   logic          accept;
   logic          direct;

   assign slot_ext = (CW + 4)'(req_slot);
   assign used_ext = (CW + 4)'(used_ff);
   assign idx_ext  = (CW + 4)'(idx_ff);
   assign slot_ok  = slot_ext < used_ext;
   assign full     = used_ff >= CW'(REGION_SLOTS);
   assign at_end   = idx_ff >= used_ff;
   assign accept   = req_valid && (state_ff == S_IDLE);
   assign direct   = (req_func == FUNC_FREE) || ((req_func == FUNC_ALLOC) && full);

   // shared range comparator
   assign cmp_lo = addr_ff < rd_entry.limit;
   assign cmp_hi = (func_ff == FUNC_ALLOC) ? (end_ff > rd_entry.base)
                                           : (addr_ff >= rd_entry.base);
   assign match  = rd_active && cmp_lo && cmp_hi;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = direct ? S_RESP : S_SCAN;
            end
         end
         S_SCAN: begin
            if (at_end || match) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      func_in      = func_ff;
      addr_in      = addr_ff;
      end_in       = end_ff;
      perm_in      = perm_ff;
      need_in      = need_ff;
      owner_in     = owner_ff;
      idx_in       = idx_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      allowed_in   = allowed_ff;
      found_in     = found_ff;
      index_in     = index_ff;
      cmd          = '0;
      wr_idx       = used_ff[IW-1:0];
      wr_entry     = '{base: addr_ff, limit: end_ff, perm: perm_ff, owner: owner_ff};
      clr_idx      = slot_ext[IW-1:0];
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept) begin
               func_in    = req_func;
               addr_in    = req_address;
               end_in     = req_address + req_length;
               perm_in    = req_perm_bits;
               need_in    = req_access_bits;
               owner_in   = req_owner;
               status_in  = STS_OK;
               allowed_in = 1'b0;
               found_in   = 1'b0;
               index_in   = 4'd0;
               if (req_func == FUNC_FREE) begin
                  rsp_valid_in = 1'b1;
                  if (slot_ok) begin
                     cmd.clr_en = 1'b1;
                  end else begin
                     status_in = STS_BADIDX;
                  end
               end else if ((req_func == FUNC_ALLOC) && full) begin
                  rsp_valid_in = 1'b1;
                  status_in    = STS_FULL;
               end
            end
         end
         S_SCAN: begin
            if (at_end) begin
               idx_in       = '0;
               rsp_valid_in = 1'b1;
               if (func_ff == FUNC_ALLOC) begin
                  cmd.wr_en = 1'b1;
                  used_in   = used_ff + CW'(1);
                  found_in  = 1'b1;
                  index_in  = used_ext[3:0];
               end else begin
                  status_in = STS_NOMATCH;
               end
            end else if (match) begin
               idx_in       = '0;
               rsp_valid_in = 1'b1;
               case (func_ff)
                  FUNC_ALLOC: status_in = STS_OVERLAP;
                  FUNC_CHECK: begin
                     if (rd_entry.owner != owner_ff) begin
                        status_in = STS_OWNER;
                     end else if ((rd_entry.perm & need_ff) != need_ff) begin
                        status_in = STS_PERM;
                     end else begin
                        allowed_in = 1'b1;
                     end
                  end
                  default: begin
                     found_in = 1'b1;
                     index_in = idx_ext[3:0];
                  end
               endcase
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_RESP: begin
            idx_in = '0;
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
            end
         end
         default: idx_in = '0;
      endcase
   end

   assign rd_addr = idx_in[IW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         used_ff      <= CW'(KERNEL_ROWS);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      addr_ff    <= addr_in;
      end_ff     <= end_in;
      perm_ff    <= perm_in;
      need_ff    <= need_in;
      owner_ff   <= owner_in;
      status_ff  <= status_in;
      allowed_ff <= allowed_in;
      found_ff   <= found_in;
      index_ff   <= index_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_allowed      = allowed_ff;
   assign rsp_found        = found_ff;
   assign rsp_region_index = index_ff;

endmodule

>>> design/memory_region_protection_table_unit.sv
// memory region protection table, top level with stream ports
// depends on mrpt_pkg, mrpt_seq, mrpt_table
//
// usage: one request word on the req_ stream gives exactly one response word on
// the rsp_ stream. a request allocates a region, checks an access, finds the
// region holding an address, or frees a slot. the table is walked from slot 0
// up to the used count by a single range comparator, one slot per cycle.
// free and allocate into a full table are answered straight from idle; allocate,
// check and find walk the slots until a hit or the end of the used slots.
// one request is in flight at a time: req_tready is high only while idle, and the
// next word is taken the cycle after the response word is accepted.
// the response stays on rsp_tdata with rsp_tvalid high while rsp_tready is low,
// and no request is taken meanwhile.
// reset loads the three kernel regions into slots 0 to 2, sets the used count to
// 3 and drops rsp_tvalid; the block is ready the first cycle after reset.
module memory_region_protection_table_unit
   import mrpt_pkg::*;
#(
   parameter int REGION_SLOTS = SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // func, address, length, perm_bits, access_bits, owner, slot, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // status, allowed, found, region_index, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IW = $clog2(REGION_SLOTS);

   tbl_cmd_type cmd;
   logic [IW-1:0] wr_idx;
   logic [IW-1:0] clr_idx;
   logic [IW-1:0] rd_addr;
   entry_type   wr_entry;
   entry_type   rd_entry;
   logic        rd_active;
   status_type  status;
   logic        allowed;
   logic        found;
   logic [3:0]  region_index;

   mrpt_seq #(
      .REGION_SLOTS(REGION_SLOTS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_func        (func_type'(req_tdata[1:0])),
      .req_address     (req_tdata[33:2]),
      .req_length      (req_tdata[65:34]),
      .req_perm_bits   (req_tdata[68:66]),
      .req_access_bits (req_tdata[71:69]),
      .req_owner       (req_tdata[79:72]),
      .req_slot        (req_tdata[83:80]),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_status      (status),
      .rsp_allowed     (allowed),
      .rsp_found       (found),
      .rsp_region_index(region_index),
      .cmd             (cmd),
      .wr_idx          (wr_idx),
      .wr_entry        (wr_entry),
      .clr_idx         (clr_idx),
      .rd_addr         (rd_addr),
      .rd_entry        (rd_entry),
      .rd_active       (rd_active)
   );

   mrpt_table #(
      .REGION_SLOTS(REGION_SLOTS)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .wr_idx   (wr_idx),
      .wr_entry (wr_entry),
      .clr_idx  (clr_idx),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .rd_active(rd_active)
   );

   assign rsp_tdata = {7'd0, region_index, found, allowed, status};

endmodule

>>> bench/memory_region_protection_table_unit_tb.sv
`timescale 1ns / 100ps
// testbench for memory_region_protection_table_unit: directed and random request words,
// each response predicted from a private copy of the region table and compared in order
// depends on mrpt_pkg and the unit under test
module memory_region_protection_table_unit_tb;
   import mrpt_pkg::*;

   localparam int TABLE_SLOTS = 16;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      func_type    func;
      logic [31:0] address;
      logic [31:0] length;
      logic [2:0]  perm_bits;
      logic [2:0]  access_bits;
      logic [7:0]  owner;
      logic [3:0]  slot;
   } request_type;

   typedef struct packed {
      status_type  status;
      logic        allowed;
      logic        found;
      logic [3:0]  region_index;
   } response_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [31:0] tbl_base   [TABLE_SLOTS];
   logic [31:0] tbl_limit  [TABLE_SLOTS];
   logic [2:0]  tbl_perm   [TABLE_SLOTS];
   logic [7:0]  tbl_owner  [TABLE_SLOTS];
   logic        tbl_active [TABLE_SLOTS];
   int          table_used;

   response_type awaited_responses[$];
   response_type seen_rsp;
   response_type want_rsp;
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  burst_left = 0;
   int unsigned  ready_mode = 0;
   logic [31:0]  next_fresh = 32'h0010_0000;

   memory_region_protection_table_unit #(
      .REGION_SLOTS(TABLE_SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      // func, address, length, perm_bits, access_bits, owner, slot, zero fill
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      // status, allowed, found, region_index, zero fill
      .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic response_type predict_response(input request_type q);
      response_type p;
      int           hit;
      logic [31:0]  tail;
      logic         clash;
      p.status = STS_OK;
      p.allowed = 1'b0;
      p.found = 1'b0;
      p.region_index = 4'd0;
      hit = -1;
      clash = 1'b0;
      tail = q.address + q.length;
      for (int i = 0; i < table_used; i++) begin
         if (hit < 0 && tbl_active[i] && q.address >= tbl_base[i] && q.address < tbl_limit[i])
            hit = i;
      end
      case (q.func)
         FUNC_ALLOC: begin
            if (table_used >= TABLE_SLOTS) begin
               p.status = STS_FULL;
            end else begin
               for (int i = 0; i < table_used; i++) begin
                  if (tbl_active[i] && q.address < tbl_limit[i] && tail > tbl_base[i])
                     clash = 1'b1;
               end
               if (clash) begin
                  p.status = STS_OVERLAP;
               end else begin
                  tbl_base[table_used] = q.address;
                  tbl_limit[table_used] = tail;
                  tbl_perm[table_used] = q.perm_bits;
                  tbl_owner[table_used] = q.owner;
                  tbl_active[table_used] = 1'b1;
                  p.found = 1'b1;
                  p.region_index = 4'(table_used);
                  table_used++;
               end
            end
         end
         FUNC_CHECK: begin
            if (hit < 0)
               p.status = STS_NOMATCH;
            else if (tbl_owner[hit] != q.owner)
               p.status = STS_OWNER;
            else if ((tbl_perm[hit] & q.access_bits) != q.access_bits)
               p.status = STS_PERM;
            else
               p.allowed = 1'b1;
         end
         FUNC_FIND: begin
            if (hit < 0) begin
               p.status = STS_NOMATCH;
            end else begin
               p.found = 1'b1;
               p.region_index = 4'(hit);
            end
         end
         default: begin
            if (int'(q.slot) < table_used)
               tbl_active[q.slot] = 1'b0;
            else
               p.status = STS_BADIDX;
         end
      endcase
      return p;
   endfunction

   function automatic request_type compose_request(input func_type f, input logic [31:0] a,
         input logic [31:0] len, input logic [2:0] perm, input logic [2:0] need,
         input logic [7:0] who, input logic [3:0] s);
      request_type q;
      q.func = f;
      q.address = a;
      q.length = len;
      q.perm_bits = perm;
      q.access_bits = need;
      q.owner = who;
      q.slot = s;
      return q;
   endfunction

   // region at the low end of the unused address space, clear of earlier ones
   function automatic request_type fresh_allocate();
      request_type q;
      q = compose_request(FUNC_ALLOC, next_fresh + $urandom_range(0, 32'hFFF),
         $urandom_range(1, 32'h8000), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
         8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      next_fresh = q.address + q.length;
      return q;
   endfunction

   function automatic request_type random_request();
      request_type q;
      int unsigned pick;
      int unsigned sel;
      int          i;
      pick = $urandom_range(0, 99);
      sel = $urandom_range(0, 19);
      i = $urandom_range(0, table_used - 1);
      q = compose_request(FUNC_FIND, $urandom, $urandom, 3'($urandom_range(0, 7)),
         3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      if (pick < 8) begin
         if (sel < 10) begin
            q = fresh_allocate();
         end else if (sel < 13) begin
            q.func = FUNC_ALLOC;
            q.address = tbl_base[i] + $urandom_range(0, 15);
            q.length = $urandom_range(0, 32'h100);
         end else if (sel < 15) begin
            q = fresh_allocate();
            q.length = 32'd0;
         end else begin
            q.func = FUNC_ALLOC;
         end
      end else if (pick < 9) begin
         q.func = FUNC_FREE;
      end else begin
         q.func = (pick < 59) ? FUNC_CHECK : FUNC_FIND;
         if (sel < 11) begin
            q.address = (tbl_limit[i] > tbl_base[i]) ?
               tbl_base[i] + ($urandom % (tbl_limit[i] - tbl_base[i])) : tbl_base[i];
            if ($urandom_range(0, 2) != 0)
               q.owner = tbl_owner[i];
         end else if (sel < 13) begin
            q.address = tbl_limit[i] - $urandom_range(0, 1);
            q.owner = tbl_owner[i];
         end else if (sel < 17) begin
            q.address = $urandom_range(0, 32'h2FFFF);
            if ($urandom_range(0, 1) != 0)
               q.owner = 8'h00;
         end
      end
      return q;
   endfunction

   task automatic send_request(input request_type q);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
      end
      burst_left--;
      req_tdata <= {4'b0, q.slot, q.owner, q.access_bits, q.perm_bits, q.length, q.address,
         q.func};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      awaited_responses.push_back(predict_response(q));
   endtask

   task automatic wait_until_answered();
      req_tvalid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic test_kernel_regions();
      send_request(compose_request(FUNC_CHECK, 32'h0000_0000, 32'h0, 3'd0, 3'd7, 8'h00, 4'd0));
      send_request(compose_request(FUNC_CHECK, 32'h0001_0000, 32'h0, 3'd0, 3'd4, 8'h00, 4'd0));
      send_request(compose_request(FUNC_CHECK, 32'h0001_FFFF, 32'h0, 3'd0, 3'd1, 8'h05, 4'd0));
      send_request(compose_request(FUNC_CHECK, 32'hFFFF_FFFF, 32'h0, 3'd0, 3'd0, 8'h00, 4'd0));
      send_request(compose_request(FUNC_CHECK, 32'h0002_0000, 32'h0, 3'd0, 3'd0, 8'h00, 4'd0));
      send_request(compose_request(FUNC_FIND, 32'h0002_FFFF, 32'h0, 3'd0, 3'd0, 8'h00, 4'd0));
      send_request(compose_request(FUNC_FIND, 32'h0003_0000, 32'h0, 3'd0, 3'd0, 8'h00, 4'd0));
   endtask

   task automatic test_allocate_cases();
      // overlap with kernel, then plain, wrapping, zero length and maximal ones
      send_request(compose_request(FUNC_ALLOC, 32'h0000_8000, 32'h10, 3'd7, 3'd0, 8'h01, 4'd0));
      send_request(compose_request(FUNC_ALLOC, 32'h0003_0000, 32'h1000, 3'd5, 3'd0, 8'h5A,
         4'd0));
      send_request(compose_request(FUNC_ALLOC, 32'hFFFF_F000, 32'h2000, 3'd7, 3'd7, 8'hFF,
         4'd15));
      send_request(compose_request(FUNC_ALLOC, 32'h0004_0000, 32'h0, 3'd0, 3'd0, 8'h00, 4'd0));
      send_request(compose_request(FUNC_ALLOC, 32'hFFFF_FFFF, 32'h1, 3'd1, 3'd0, 8'h80, 4'd0));
      send_request(compose_request(FUNC_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF, 3'd7, 3'd0,
         8'h00, 4'd0));
      send_request(compose_request(FUNC_FIND, 32'h0004_0000, 32'h0, 3'd0, 3'd0, 8'h00, 4'd0));
      send_request(compose_request(FUNC_CHECK, 32'h0003_0010, 32'h0, 3'd0, 3'd5, 8'h5A, 4'd0));
      send_request(compose_request(FUNC_CHECK, 32'h0003_0FFF, 32'h0, 3'd0, 3'd2, 8'h5A, 4'd0));
      send_request(compose_request(FUNC_CHECK, 32'h0003_0010, 32'h0, 3'd0, 3'd1, 8'h5B, 4'd0));
   endtask

   task automatic test_free_cases();
      send_request(compose_request(FUNC_FREE, 32'h0, 32'h0, 3'd0, 3'd0, 8'h00, 4'd15));
      send_request(compose_request(FUNC_FREE, 32'h0, 32'h0, 3'd0, 3'd0, 8'h00,
         4'(table_used)));
      send_request(compose_request(FUNC_FREE, 32'h0, 32'h0, 3'd0, 3'd0, 8'h00, 4'd3));
      send_request(compose_request(FUNC_FREE, 32'h0, 32'h0, 3'd0, 3'd0, 8'h00, 4'd3));
      send_request(compose_request(FUNC_FIND, 32'h0003_0800, 32'h0, 3'd0, 3'd0, 8'h00, 4'd0));
      send_request(compose_request(FUNC_CHECK, 32'h0003_0800, 32'h0, 3'd0, 3'd1, 8'h5A, 4'd0));
      send_request(compose_request(FUNC_ALLOC, 32'h0003_0000, 32'h100, 3'd6, 3'd0, 8'h22,
         4'd0));
   endtask

   task automatic test_random_traffic(input int count);
      for (int n = 0; n < count; n++) begin
         if (n == count / 2)
            wait_until_answered();
         send_request(random_request());
      end
   endtask

   task automatic test_table_full();
      for (int k = 0; k < 60 && table_used < TABLE_SLOTS; k++)
         send_request(fresh_allocate());
      send_request(fresh_allocate());
      send_request(compose_request(FUNC_ALLOC, $urandom, $urandom, 3'd7, 3'd7, 8'hFF, 4'd15));
      for (int k = 0; k < 10; k++)
         send_request(random_request());
   endtask

   // response side: each accepted word is checked in order; rsp_tready follows a stall pattern chosen at random
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_rsp.status = status_type'(rsp_tdata[2:0]);
         seen_rsp.allowed = rsp_tdata[3];
         seen_rsp.found = rsp_tdata[4];
         seen_rsp.region_index = rsp_tdata[8:5];
         if (awaited_responses.size() == 0) begin
            $display("%0t unexpected response word %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            want_rsp = awaited_responses.pop_front();
            if (seen_rsp !== want_rsp) begin
               $display("%0t response mismatch: expected status %0d allowed %0b found %0b %s%0d",
                  $time, want_rsp.status, want_rsp.allowed, want_rsp.found, "index ",
                  want_rsp.region_index);
               $display("%0t                    actual   status %0d allowed %0b found %0b %s%0d",
                  $time, seen_rsp.status, seen_rsp.allowed, seen_rsp.found, "index ",
                  seen_rsp.region_index);
               mismatch_count++;
            end
         end
      end
      if (cycle_count % 256 == 0)
         ready_mode = $urandom_range(0, 2);
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= (cycle_count % 5 < 2);
      endcase
   end

   initial begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         tbl_base[i] = 32'h0;
         tbl_limit[i] = 32'h0;
         tbl_perm[i] = 3'd0;
         tbl_owner[i] = 8'h00;
         tbl_active[i] = 1'b0;
      end
      tbl_base[0] = 32'h0000_0000;
      tbl_limit[0] = 32'h0001_0000;
      tbl_perm[0] = 3'd7;
      tbl_base[1] = 32'h0001_0000;
      tbl_limit[1] = 32'h0002_0000;
      tbl_perm[1] = 3'd3;
      tbl_base[2] = 32'h0002_0000;
      tbl_limit[2] = 32'h0003_0000;
      tbl_perm[2] = 3'd3;
      tbl_active[0] = 1'b1;
      tbl_active[1] = 1'b1;
      tbl_active[2] = 1'b1;
      table_used = 3;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_kernel_regions();
      test_allocate_cases();
      test_free_cases();
      test_random_traffic(1700);
      test_table_full();
      wait_until_answered();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> memory_region_protection_table_unit.f
design/mrpt_pkg.sv
design/mrpt_table.sv
design/mrpt_seq.sv
design/memory_region_protection_table_unit.sv
bench/memory_region_protection_table_unit_tb.sv
